/* rtl/ssdu_pkg.sv */
package ssdu_pkg;

    // Input opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_INV_EDGE_X = 3'd0;
    localparam logic [2:0] CFG_INV_EDGE_Y = 3'd1;
    localparam logic [2:0] CFG_INV_EDGE_Z = 3'd2;
    localparam logic [2:0] CFG_SIZE_X     = 3'd3;
    localparam logic [2:0] CFG_SIZE_Y     = 3'd4;
    localparam logic [2:0] CFG_SIZE_Z     = 3'd5;

    localparam int NUM_OUT = 12;
    localparam int DERIV_W = 49;
    localparam int ACC_W   = 50;

    // Result slots holding a shear component (yz, xz, xy of strain and rate).
    localparam logic [NUM_OUT-1:0] SHEAR_MASK = 12'b111000_111000;

    // One stored cell: displacement, displacement rate and magnetic flag.
    typedef struct packed {
        logic             mag;
        logic [2:0][31:0] rate;
        logic [2:0][31:0] disp;
    } cell_word_t;

    // One operation for the shared derivative unit.
    typedef struct packed {
        logic               valid;
        logic               central;
        logic [3:0]         slot;
        logic [31:0]        inv;
        logic signed [31:0] hi;
        logic signed [31:0] lo;
    } deriv_op_t;

    // One derivative leaving the unit, tagged with its result slot.
    typedef struct packed {
        logic                      valid;
        logic [3:0]                slot;
        logic signed [DERIV_W-1:0] value;
    } deriv_res_t;

    // Result slot of the derivative of component comp along axis ax.
    function automatic logic [3:0] acc_slot(logic kind, logic [1:0] ax, logic [1:0] comp);
        logic [3:0] s;
        if (ax == comp) begin
            s = {2'b00, ax};
        end else begin
            s = 4'd6 - {2'b00, ax} - {2'b00, comp};
        end
        if (kind) begin
            s = s + 4'd6;
        end
        return s;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic [31:0] sat32(logic signed [ACC_W-1:0] v);
        logic [31:0] r;
        if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
            r = v[31:0];
        end else if (v[ACC_W-1]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

/* rtl/ssdu_ram.sv */
module ssdu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ssdu_deriv.sv */
module ssdu_deriv import ssdu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  deriv_op_t  op,
    output deriv_res_t res,
    output logic       busy
);

    // Stage 1: difference of the two samples.
    logic               v1_reg;
    logic signed [32:0] diff1_reg;
    logic [31:0]        inv1_reg;
    logic               c1_reg;
    logic [3:0]         slot1_reg;
    // Stage 2: product with the inverse edge length.
    logic               v2_reg;
    logic signed [64:0] prod2_reg;
    logic               c2_reg;
    logic [3:0]         slot2_reg;
    // Stage 3: scaled derivative.
    logic                      v3_reg;
    logic signed [DERIV_W-1:0] val3_reg;
    logic [3:0]                slot3_reg;

    logic signed [32:0]        diff1_next;
    logic signed [65:0]        prod_full;
    logic signed [DERIV_W-1:0] val3_next;

    assign diff1_next = $signed({op.hi[31], op.hi}) - $signed({op.lo[31], op.lo});
    assign prod_full  = diff1_reg * $signed({1'b0, inv1_reg});

    // An arithmetic shift floors; a central difference also halves.
    assign val3_next = c2_reg ? {prod2_reg[64], prod2_reg[64:17]} : prod2_reg[64:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= op.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        diff1_reg <= diff1_next;
        inv1_reg  <= op.inv;
        c1_reg    <= op.central;
        slot1_reg <= op.slot;
        prod2_reg <= prod_full[64:0];
        c2_reg    <= c1_reg;
        slot2_reg <= slot1_reg;
        val3_reg  <= val3_next;
        slot3_reg <= slot2_reg;
    end

    assign res.valid = v3_reg;
    assign res.slot  = slot3_reg;
    assign res.value = val3_reg;
    assign busy      = v1_reg | v2_reg | v3_reg;

endmodule

/* rtl/ssdu_accum.sv */
module ssdu_accum import ssdu_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  deriv_res_t                  res,
    input  logic                        load,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic                        out_free,
    output logic [NUM_OUT-1:0][31:0]    out_data
);

    logic signed [ACC_W-1:0] acc_reg [NUM_OUT];
    logic [NUM_OUT-1:0][31:0] out_data_reg;
    logic                     out_valid_reg;

    // Normal components take one derivative, shear components sum two.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_OUT; i++) begin
            if (clear) begin
                acc_reg[i] <= '0;
            end else if (res.valid && (res.slot == 4'(i))) begin
                acc_reg[i] <= acc_reg[i] + $signed({res.value[DERIV_W-1], res.value});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < NUM_OUT; i++) begin
                out_data_reg[i] <= SHEAR_MASK[i] ? sat32(acc_reg[i] >>> 1) : sat32(acc_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_data  = out_data_reg;

endmodule

/* rtl/strain_from_displacement_stencil_unit.sv */
// Channel  | Handshake           | Word
// ---------+---------------------+---------------------------------------------------
// s_       | s_valid / s_ready   | opcode, cell coordinates, displacement, rate, flag
// m_       | m_valid / m_ready   | six strain components and their six rates
// cfg_     | cfg_valid/cfg_ready | register index and 32-bit write data
//
// After reset the block sweeps the cell store once, one cell a cycle over all DIM_X*DIM_Y*DIM_Z
// cells (4096 by default), to clear the magnetic flags; s_ready stays low meanwhile.
// A write word is stored as it is accepted. A query of a magnetic cell makes seven reads
// through the cell store's one read port plus eighteen passes through the one shared
// subtract-multiply-shift unit, one derivative per cycle. Queries that hit a
// non-magnetic or out-of-mesh cell make no pass through that unit and give zeros.
// A finished result waits in the output register, so the next word is taken while
// m_ready is low; only a second result stalls until the first one is taken.
module strain_from_displacement_stencil_unit import ssdu_pkg::*; #(
    parameter int DIM_X = 16,
    parameter int DIM_Y = 16,
    parameter int DIM_Z = 16
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [3:0]         s_cell_x,
    input  logic [3:0]         s_cell_y,
    input  logic [3:0]         s_cell_z,
    input  logic signed [31:0] s_disp_in_x,
    input  logic signed [31:0] s_disp_in_y,
    input  logic signed [31:0] s_disp_in_z,
    input  logic signed [31:0] s_rate_in_x,
    input  logic signed [31:0] s_rate_in_y,
    input  logic signed [31:0] s_rate_in_z,
    input  logic               s_magnetic_in,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_strain_xx,
    output logic signed [31:0] m_strain_yy,
    output logic signed [31:0] m_strain_zz,
    output logic signed [31:0] m_strain_yz,
    output logic signed [31:0] m_strain_xz,
    output logic signed [31:0] m_strain_xy,
    output logic signed [31:0] m_rate_xx,
    output logic signed [31:0] m_rate_yy,
    output logic signed [31:0] m_rate_zz,
    output logic signed [31:0] m_rate_yz,
    output logic signed [31:0] m_rate_xz,
    output logic signed [31:0] m_rate_xy,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int NCELLS = DIM_X * DIM_Y * DIM_Z;
    localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int CW     = $bits(cell_word_t);

    localparam logic [8:0] DIM_X9 = 9'(DIM_X);
    localparam logic [8:0] DIM_Y9 = 9'(DIM_Y);
    localparam logic [8:0] DIM_Z9 = 9'(DIM_Z);

    // The sequencer walks the center cell, then for each axis the upper and lower
    // neighbor, then issues that axis's six derivatives into the shared unit.
    typedef enum logic [9:0] {
        ST_CLEAR   = 10'b00_0000_0001,
        ST_IDLE    = 10'b00_0000_0010,
        ST_CTR_RD  = 10'b00_0000_0100,
        ST_CTR_CHK = 10'b00_0000_1000,
        ST_UP_RD   = 10'b00_0001_0000,
        ST_DN_RD   = 10'b00_0010_0000,
        ST_NB_LAT  = 10'b00_0100_0000,
        ST_CALC    = 10'b00_1000_0000,
        ST_DRAIN   = 10'b01_0000_0000,
        ST_DONE    = 10'b10_0000_0000
    } state_t;

    // Linear store address of a cell.
    function automatic logic [AW-1:0] cell_addr(logic [8:0] x, logic [8:0] y, logic [8:0] z);
        logic [31:0] idx;
        idx = 32'(x) + 32'(DIM_X) * (32'(y) + 32'(DIM_Y) * 32'(z));
        return idx[AW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [AW-1:0] clear_addr_reg;
    logic [3:0]    cx_reg, cy_reg, cz_reg;
    logic [1:0]    axis_reg;
    logic [2:0]    cnt_reg;
    logic          ok_up_reg;
    logic          central_reg;
    cell_word_t    center_reg, hi_reg, lo_reg;

    logic [31:0] inv_edge_x_reg, inv_edge_y_reg, inv_edge_z_reg;
    logic [4:0]  size_x_reg, size_y_reg, size_z_reg;

    logic        in_accept;
    logic        w_in_range;
    logic        q_in_range;
    logic [8:0]  size_eff_x, size_eff_y, size_eff_z;
    logic [8:0]  cx9, cy9, cz9;
    logic [8:0]  ca, sa, up_c, dn_c;
    logic        up_in, dn_in;
    logic [8:0]  rx, ry, rz;
    logic        ok_up_now, ok_dn_now;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    cell_word_t    ram_wdata;
    cell_word_t    wr_word;
    logic [AW-1:0] ram_raddr;
    cell_word_t    rd_word;
    logic [CW-1:0] ram_rdata;

    logic [1:0]  comp;
    logic        kind;
    logic [31:0] inv_sel;
    deriv_op_t   op;
    deriv_res_t  res;
    logic        unit_busy;

    logic        acc_clear;
    logic        out_load;
    logic        out_free;
    logic [NUM_OUT-1:0][31:0] out_data;

    // Configuration writes are always taken; an index past the list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_edge_x_reg <= 32'd65536;
            inv_edge_y_reg <= 32'd65536;
            inv_edge_z_reg <= 32'd65536;
            size_x_reg     <= 5'd16;
            size_y_reg     <= 5'd16;
            size_z_reg     <= 5'd16;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_INV_EDGE_X: inv_edge_x_reg <= cfg_data;
                CFG_INV_EDGE_Y: inv_edge_y_reg <= cfg_data;
                CFG_INV_EDGE_Z: inv_edge_z_reg <= cfg_data;
                CFG_SIZE_X:     size_x_reg     <= cfg_data[4:0];
                CFG_SIZE_Y:     size_y_reg     <= cfg_data[4:0];
                CFG_SIZE_Z:     size_z_reg     <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // The size in use is the register clamped to the store's dimension.
    assign size_eff_x = ({4'b0, size_x_reg} > DIM_X9) ? DIM_X9 : {4'b0, size_x_reg};
    assign size_eff_y = ({4'b0, size_y_reg} > DIM_Y9) ? DIM_Y9 : {4'b0, size_y_reg};
    assign size_eff_z = ({4'b0, size_z_reg} > DIM_Z9) ? DIM_Z9 : {4'b0, size_z_reg};

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;

    // A write outside the store is dropped; a query outside the mesh in use gives zeros.
    assign w_in_range = ({5'b0, s_cell_x} < DIM_X9) && ({5'b0, s_cell_y} < DIM_Y9)
                     && ({5'b0, s_cell_z} < DIM_Z9);
    assign q_in_range = ({5'b0, s_cell_x} < size_eff_x) && ({5'b0, s_cell_y} < size_eff_y)
                     && ({5'b0, s_cell_z} < size_eff_z);

    // Neighbor coordinates along the current axis. A neighbor outside the mesh
    // in use is replaced by the center cell so the address stays in the store.
    assign cx9 = {5'b0, cx_reg};
    assign cy9 = {5'b0, cy_reg};
    assign cz9 = {5'b0, cz_reg};

    always_comb begin
        case (axis_reg)
            2'd0:    begin ca = cx9; sa = size_eff_x; inv_sel = inv_edge_x_reg; end
            2'd1:    begin ca = cy9; sa = size_eff_y; inv_sel = inv_edge_y_reg; end
            default: begin ca = cz9; sa = size_eff_z; inv_sel = inv_edge_z_reg; end
        endcase
    end

    assign up_in = (ca + 9'd1) < sa;
    assign dn_in = (ca != 9'd0);
    assign up_c  = up_in ? ca + 9'd1 : ca;
    assign dn_c  = dn_in ? ca - 9'd1 : ca;

    always_comb begin
        rx = cx9;
        ry = cy9;
        rz = cz9;
        if (state_reg == ST_UP_RD || state_reg == ST_DN_RD) begin
            case (axis_reg)
                2'd0:    rx = (state_reg == ST_UP_RD) ? up_c : dn_c;
                2'd1:    ry = (state_reg == ST_UP_RD) ? up_c : dn_c;
                default: rz = (state_reg == ST_UP_RD) ? up_c : dn_c;
            endcase
        end
    end

    assign ram_raddr = cell_addr(rx, ry, rz);

    // Write port: the clearing sweep after reset, otherwise write words.
    always_comb begin
        wr_word.mag     = s_magnetic_in;
        wr_word.disp[0] = s_disp_in_x;
        wr_word.disp[1] = s_disp_in_y;
        wr_word.disp[2] = s_disp_in_z;
        wr_word.rate[0] = s_rate_in_x;
        wr_word.rate[1] = s_rate_in_y;
        wr_word.rate[2] = s_rate_in_z;
    end

    assign ram_we    = (state_reg == ST_CLEAR)
                    || (in_accept && (s_opcode == OP_WRITE) && w_in_range);
    assign ram_waddr = (state_reg == ST_CLEAR)
                     ? clear_addr_reg
                     : cell_addr({5'b0, s_cell_x}, {5'b0, s_cell_y}, {5'b0, s_cell_z});
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : wr_word;

    ssdu_ram #(
        .WIDTH (CW),
        .DEPTH (NCELLS)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_word = ram_rdata;

    // A neighbor qualifies when it lies in the mesh in use and is magnetic.
    assign ok_up_now = up_in && rd_word.mag;
    assign ok_dn_now = dn_in && rd_word.mag;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clear_addr_reg == AW'(NCELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept && (s_opcode == OP_QUERY)) begin
                    state_next = q_in_range ? ST_CTR_RD : ST_DONE;
                end
            end
            ST_CTR_RD:  state_next = ST_CTR_CHK;
            ST_CTR_CHK: state_next = rd_word.mag ? ST_UP_RD : ST_DONE;
            ST_UP_RD:   state_next = ST_DN_RD;
            ST_DN_RD:   state_next = ST_NB_LAT;
            ST_NB_LAT:  state_next = ST_CALC;
            ST_CALC: begin
                if (cnt_reg == 3'd5) begin
                    state_next = (axis_reg == 2'd2) ? ST_DRAIN : ST_UP_RD;
                end
            end
            ST_DRAIN: begin
                if (!unit_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            axis_reg       <= 2'd0;
            cnt_reg        <= 3'd0;
            ok_up_reg      <= 1'b0;
            central_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
            if (state_reg == ST_CTR_CHK) begin
                axis_reg <= 2'd0;
            end
            if (state_reg == ST_NB_LAT) begin
                cnt_reg     <= 3'd0;
                central_reg <= ok_up_reg && ok_dn_now;
            end
            if (state_reg == ST_DN_RD) begin
                ok_up_reg <= ok_up_now;
            end
            if (state_reg == ST_CALC) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    axis_reg <= axis_reg + 2'd1;
                end
            end
        end
    end

    // Coordinates and cell words; a missing neighbor takes the center cell's value.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cx_reg <= s_cell_x;
            cy_reg <= s_cell_y;
            cz_reg <= s_cell_z;
        end
        if (state_reg == ST_CTR_CHK) begin
            center_reg <= rd_word;
        end
        if (state_reg == ST_DN_RD) begin
            hi_reg <= ok_up_now ? rd_word : center_reg;
        end
        if (state_reg == ST_NB_LAT) begin
            lo_reg <= ok_dn_now ? rd_word : center_reg;
        end
    end

    // Six derivatives per axis: the step count picks component and disp/rate.
    assign comp = cnt_reg[2:1];
    assign kind = cnt_reg[0];

    always_comb begin
        op.valid   = (state_reg == ST_CALC);
        op.central = central_reg;
        op.slot    = acc_slot(kind, axis_reg, comp);
        op.inv     = inv_sel;
        op.hi      = kind ? hi_reg.rate[comp] : hi_reg.disp[comp];
        op.lo      = kind ? lo_reg.rate[comp] : lo_reg.disp[comp];
    end

    ssdu_deriv u_deriv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .res     (res),
        .busy    (unit_busy)
    );

    assign acc_clear = in_accept && (s_opcode == OP_QUERY);
    assign out_load  = (state_reg == ST_DONE) && out_free;

    ssdu_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (acc_clear),
        .res       (res),
        .load      (out_load),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_free  (out_free),
        .out_data  (out_data)
    );

    assign m_strain_xx = out_data[0];
    assign m_strain_yy = out_data[1];
    assign m_strain_zz = out_data[2];
    assign m_strain_yz = out_data[3];
    assign m_strain_xz = out_data[4];
    assign m_strain_xy = out_data[5];
    assign m_rate_xx   = out_data[6];
    assign m_rate_yy   = out_data[7];
    assign m_rate_zz   = out_data[8];
    assign m_rate_yz   = out_data[9];
    assign m_rate_xz   = out_data[10];
    assign m_rate_xy   = out_data[11];

    // The store is written only by the clearing sweep or by an accepted word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("cell store written while a query is in progress");

    // Derivatives leave the shared unit only while a query still collects them.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (state_reg == ST_CALC || state_reg == ST_UP_RD ||
                       state_reg == ST_DN_RD || state_reg == ST_NB_LAT ||
                       state_reg == ST_DRAIN))
        else $error("derivative arrived outside a query");

    // A result word is dropped only when the consumer has taken it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result word lost before it was taken");

    // An in-mesh query starts by reading its center cell.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (s_opcode == OP_QUERY) && q_in_range) |=> (state_reg == ST_CTR_RD))
        else $error("query did not start its center read");

    // No result is presented before the clearing sweep has ended.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_valid)
        else $error("result presented during the clearing sweep");

endmodule
